/* src/mat4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_pkg: shared types and constants of the matrix multiplier
// Matrix size, arithmetic widths, command codes, the token handed along the
// chain of multiply-accumulate cells and the element write bus.
// ----------------------------------------------------------------------------
package mat4_pkg;

	// Matrix size and derived widths
	localparam int DIM    = 4;
	localparam int NELEM  = DIM * DIM;
	localparam int RC_W   = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int POS_W  = (NELEM > 1) ? $clog2(NELEM) : 1;

	// Fixed field widths of the stream words
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 32;
	localparam int WORD_W = 40;

	// Arithmetic: Q16.16 operands, exact sum of DIM full products
	localparam int FRAC   = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int SUM_W  = PROD_W + $clog2(DIM);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WR_LEFT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_RIGHT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

	// Token moving down the cell chain: one product element in progress
	typedef struct packed {
		logic             valid;
		logic [RC_W-1:0]  row;
		logic [RC_W-1:0]  col;
		logic [POS_W-1:0] pos;
		logic [SUM_W-1:0] sum;
	} tok_t;

	// Element write broadcast to every cell
	typedef struct packed {
		logic             left_en;
		logic             right_en;
		logic [RC_W-1:0]  row;
		logic [RC_W-1:0]  col;
		logic [VAL_W-1:0] value;
	} wr_t;

	// Row of a linear element index (small compare table)
	function automatic logic [RC_W-1:0] row_of(input logic [IDX_W-1:0] idx);
		logic [RC_W-1:0] row;
		row = '0;
		for (int r = 0; r < DIM; r++) begin
			if (int'(idx) >= r * DIM) begin
				row = RC_W'(r);
			end
		end
		return row;
	endfunction

	// Column of a linear element index
	function automatic logic [RC_W-1:0] col_of(input logic [IDX_W-1:0] idx);
		int rem;
		rem = int'(idx) - int'(row_of(idx)) * DIM;
		return RC_W'(rem);
	endfunction

endpackage

/* src/mat4_mac_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_mac_cell: one multiply-accumulate cell of the chain
// Cell k holds column k of the left matrix and row k of the right matrix,
// multiplies the pair picked by the incoming token and adds the product to
// the running sum before handing the token to the next cell.
// ----------------------------------------------------------------------------
module mat4_mac_cell
	import mat4_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [RC_W-1:0] cell_id,
	input  wr_t             wr,
	input  tok_t            tok_in,
	output tok_t            tok_out
);

	logic [VAL_W-1:0]         left_q  [DIM];
	logic [VAL_W-1:0]         right_q [DIM];
	logic signed [VAL_W-1:0]  op_a;
	logic signed [VAL_W-1:0]  op_b;
	tok_t                     tok_s1;
	logic signed [PROD_W-1:0] prod_s1;
	tok_t                     tok_s2;

	// Hold this cell's share of both matrices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM; i++) begin
				left_q[i]  <= '0;
				right_q[i] <= '0;
			end
		end else begin
			if (wr.left_en && wr.col == cell_id) begin
				left_q[wr.row] <= wr.value;
			end
			if (wr.right_en && wr.row == cell_id) begin
				right_q[wr.col] <= wr.value;
			end
		end
	end

	// Pick operands for the token's row and column
	assign op_a = signed'(left_q[tok_in.row]);
	assign op_b = signed'(right_q[tok_in.col]);

	// Multiply, then accumulate into the token's sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			prod_s1 <= '0;
			tok_s2  <= '0;
		end else if (adv) begin
			tok_s1       <= tok_in;
			prod_s1      <= op_a * op_b;
			tok_s2.valid <= tok_s1.valid;
			tok_s2.row   <= tok_s1.row;
			tok_s2.col   <= tok_s1.col;
			tok_s2.pos   <= tok_s1.pos;
			tok_s2.sum   <= tok_s1.sum +
				{{(SUM_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	assign tok_out = tok_s2;

endmodule

/* src/mat4_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_multiply: 4x4 Q16.16 matrix multiplier
// Stores two matrices written element by element and streams out their
// product, one element per word, through a chain of multiply-accumulate cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a command in s_tuser. Commands write left or right
//   element (row*4+col), one word per cycle while idle; they
//   give no output. Command 3 is taken and ignored.
//   A multiply command starts a sequencer that issues the sixteen elements
//   into the cell chain one per cycle while the output is not stalled;
//   each cell adds one of the four products, registering first the product
//   and then the sum. Products leave one per cycle while the output is
//   not stalled, with tlast on the sixteenth. The block takes the next
//   word once the last product has been taken.
//   s_tready is low during a multiply. While m_tvalid is high and m_tready
//   is low, output register, whole cell chain and sequencer hold; nothing is lost.
//   Reset clears both matrices to zero and empties the chain.
// ----------------------------------------------------------------------------
module mat4_multiply
	import mat4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // element_index[3:0], element_value[35:4]
	input  logic [CMD_W-1:0]  s_tuser,   // command[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,   // result_index[3:0], result_value[35:4]
	output logic [0:0]        m_tuser,   // saturated[0]
	output logic              m_tlast
);

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

	state_t             state_q;
	logic [RC_W-1:0]    row_q;
	logic [RC_W-1:0]    col_q;
	logic [POS_W-1:0]   pos_q;
	logic               in_acc;
	logic               out_acc;
	logic               adv;
	logic [IDX_W-1:0]   in_idx;
	logic               in_range;
	wr_t                wr;
	tok_t               chain [DIM+1];
	tok_t               tok_end;
	logic [SUM_W-FRAC-VAL_W:0] hi_bits;
	logic               fits;
	logic [VAL_W-1:0]   res_val;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign adv     = !m_tvalid || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Decode element writes
	assign in_idx   = s_tdata[IDX_W-1:0];
	assign in_range = int'(in_idx) < NELEM;
	always_comb begin
		wr.left_en  = in_acc && in_range && s_tuser == CMD_WR_LEFT;
		wr.right_en = in_acc && in_range && s_tuser == CMD_WR_RIGHT;
		wr.row      = row_of(in_idx);
		wr.col      = col_of(in_idx);
		wr.value    = s_tdata[IDX_W+VAL_W-1:IDX_W];
	end

	// Issue a fresh token into the first cell
	always_comb begin
		chain[0].valid = (state_q == ST_ISSUE);
		chain[0].row   = row_q;
		chain[0].col   = col_q;
		chain[0].pos   = pos_q;
		chain[0].sum   = '0;
	end

	// Chain of cells, one per inner-product term
	for (genvar k = 0; k < DIM; k++) begin : g_cell
		mat4_mac_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.cell_id (RC_W'(k)),
			.wr      (wr),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	assign tok_end = chain[DIM];

	// Shift by the fraction width and clamp to 32 bits
	assign hi_bits = tok_end.sum[SUM_W-1:FRAC+VAL_W-1];
	assign fits    = (&hi_bits) || !(|hi_bits);
	always_comb begin
		if (fits) begin
			res_val = tok_end.sum[FRAC+VAL_W-1:FRAC];
		end else if (tok_end.sum[SUM_W-1]) begin
			res_val = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			res_val = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			pos_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == CMD_MULTIPLY) begin
						state_q <= ST_ISSUE;
						row_q   <= '0;
						col_q   <= '0;
						pos_q   <= '0;
					end
				end
				ST_ISSUE: begin
					if (adv) begin
						pos_q <= pos_q + 1'b1;
						if (col_q == RC_W'(DIM-1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						if (pos_q == POS_W'(NELEM-1)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_acc && m_tlast) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (adv) begin
				m_tvalid <= tok_end.valid;
				m_tdata  <= {{(WORD_W-IDX_W-VAL_W){1'b0}}, res_val, IDX_W'(tok_end.pos)};
				m_tuser  <= !fits;
				m_tlast  <= tok_end.pos == POS_W'(NELEM-1);
			end
		end
	end

	// Results only appear while a multiply is in progress
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_q != ST_IDLE)
		else $error("output word while idle");

	// Taking the final product returns the block to idle
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tlast |=> state_q == ST_IDLE)
		else $error("multiply did not end after final product");

	// The chain is empty whenever the block is idle
	a_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !tok_end.valid)
		else $error("token left in chain while idle");

	// A clamped element carries one of the two range limits
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata[IDX_W+VAL_W-1:IDX_W] == {1'b1, {(VAL_W-1){1'b0}}} ||
			 m_tdata[IDX_W+VAL_W-1:IDX_W] == {1'b0, {(VAL_W-1){1'b1}}}))
		else $error("saturated element not at range limit");

endmodule

/* tb/mat4_multiply_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_multiply_checker: scoreboard for the 4x4 Q16.16 matrix multiplier
// Watches both stream channels. Keeps its own copy of the two matrices,
// works out the sixteen product words for every multiply command, and
// compares each output word field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module mat4_multiply_checker
	import mat4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,
	input  logic [CMD_W-1:0]  s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [WORD_W-1:0] m_tdata,
	input  logic [0:0]        m_tuser,
	input  logic              m_tlast,
	output int                error_count,
	output int                pending_count,
	output int                checked_count
);

	typedef struct {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             sat;
		logic             last;
	} product_word_t;

	logic [VAL_W-1:0] left_store  [NELEM];
	logic [VAL_W-1:0] right_store [NELEM];
	product_word_t    product_queue [$];

	// Exact dot product of one row and one column, floored by 2^16, then clamped
	function automatic void product_element(input int pos, output logic [VAL_W-1:0] value,
			output logic sat);
		logic signed [PROD_W+1:0] acc;
		logic signed [PROD_W+1:0] term;
		logic signed [PROD_W-1:0] prod;
		int row;
		int col;
		row = pos / DIM;
		col = pos % DIM;
		acc = '0;
		for (int k = 0; k < DIM; k++) begin
			prod = $signed(left_store[row * DIM + k]) * $signed(right_store[k * DIM + col]);
			term = prod;
			acc  = acc + term;
		end
		acc = acc >>> FRAC;
		sat = 1'b1;
		if (acc > 66'sd2147483647) begin
			value = 32'h7FFF_FFFF;
		end else if (acc < -66'sd2147483648) begin
			value = 32'h8000_0000;
		end else begin
			value = acc[VAL_W-1:0];
			sat   = 1'b0;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Track writes, predict products and compare output words
	always @(posedge clk or negedge arst_n) begin
		product_word_t    want;
		logic [IDX_W-1:0] idx;
		if (!arst_n) begin
			foreach (left_store[i]) left_store[i] = '0;
			foreach (right_store[i]) right_store[i] = '0;
			product_queue.delete();
			error_count   = 0;
			pending_count = 0;
			checked_count = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				idx = s_tdata[IDX_W-1:0];
				case (s_tuser)
					CMD_WR_LEFT: begin
						if (idx < NELEM) left_store[idx] = s_tdata[IDX_W +: VAL_W];
					end
					CMD_WR_RIGHT: begin
						if (idx < NELEM) right_store[idx] = s_tdata[IDX_W +: VAL_W];
					end
					CMD_MULTIPLY: begin
						for (int p = 0; p < NELEM; p++) begin
							want.index = IDX_W'(p);
							product_element(p, want.value, want.sat);
							want.last  = (p == NELEM - 1);
							product_queue.push_back(want);
						end
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (product_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected word index %0d value %h",
						m_tdata[IDX_W-1:0], m_tdata[IDX_W +: VAL_W]));
				end else begin
					want = product_queue.pop_front();
					checked_count++;
					if (m_tdata[IDX_W-1:0] !== want.index)
						report_mismatch($sformatf("index %0d, wanted %0d",
							m_tdata[IDX_W-1:0], want.index));
					if (m_tdata[IDX_W +: VAL_W] !== want.value)
						report_mismatch($sformatf("element %0d value %h, wanted %h",
							want.index, m_tdata[IDX_W +: VAL_W], want.value));
					if (m_tuser[0] !== want.sat)
						report_mismatch($sformatf("element %0d saturated %b, wanted %b",
							want.index, m_tuser[0], want.sat));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("element %0d tlast %b, wanted %b",
							want.index, m_tlast, want.last));
				end
			end
			pending_count = product_queue.size();
		end
	end

endmodule

/* tb/mat4_multiply_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_multiply_test: stimulus and verdict for the matrix multiplier
// Writes matrix elements and issues multiplies, first a directed set of
// corner values, then random words under three idling patterns. The checker
// beside the block predicts and compares every product word.
// ----------------------------------------------------------------------------
module mat4_multiply_test
	import mat4_pkg::*;
();

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PAD_W      = WORD_W - VAL_W - IDX_W;
	localparam int CYCLE_CAP  = 400000;
	localparam int DRAIN_WAIT = 40;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata;
	logic [CMD_W-1:0]  s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [WORD_W-1:0] m_tdata;
	logic [0:0]        m_tuser;
	logic              m_tlast;

	int error_count;
	int pending_count;
	int checked_count;
	int tx_idle_pct;
	int rx_idle_pct;
	int words_sent;
	int multiplies_sent;
	int cycle_count;

	mat4_multiply dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	mat4_multiply_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.error_count   (error_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stall the output side at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_count);
			$display("mat4_multiply_test: errors");
			$finish;
		end
	end

	// Present one input word, with random gaps ahead of it, and hold until taken
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{PAD_W{1'b0}}, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		words_sent++;
		if (cmd == CMD_MULTIPLY) multiplies_sent++;
	endtask

	// Mostly moderate Q16.16 values, with extremes and full-range noise mixed in
	function automatic logic [VAL_W-1:0] pick_value();
		int mag;
		mag = $urandom_range(0, 9);
		case (mag)
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2, 3:    return $urandom;
			default: return VAL_W'(int'($urandom_range(0, 32'h3F_FFFF)) - 32'h20_0000);
		endcase
	endfunction

	task automatic send_random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 44)
			send_word(CMD_WR_LEFT, IDX_W'($urandom_range(0, NELEM - 1)), pick_value());
		else if (pick < 88)
			send_word(CMD_WR_RIGHT, IDX_W'($urandom_range(0, NELEM - 1)), pick_value());
		else if (pick < 96)
			send_word(CMD_MULTIPLY, IDX_W'($urandom), $urandom);
		else
			send_word(CMD_UNUSED, IDX_W'($urandom), $urandom);
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = CMD_WR_LEFT;
		tx_idle_pct     = 24;
		rx_idle_pct     = 57;
		words_sent      = 0;
		multiplies_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: freshly cleared stores give an all-zero product
		send_word(CMD_MULTIPLY, 4'hF, 32'hFFFF_FFFF);
		// Unused command must leave the stores untouched
		send_word(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF);
		// Most negative squared: positive overflow
		send_word(CMD_WR_LEFT, 4'h0, 32'h8000_0000);
		send_word(CMD_WR_RIGHT, 4'h0, 32'h8000_0000);
		send_word(CMD_MULTIPLY, 4'h0, 32'h0);
		// Most negative times most positive: negative overflow
		send_word(CMD_WR_RIGHT, 4'h0, 32'h7FFF_FFFF);
		send_word(CMD_MULTIPLY, 4'h0, 32'h0);
		// Smallest negative product floors to minus one LSB; far corner overflows
		send_word(CMD_WR_LEFT, 4'hF, 32'h7FFF_FFFF);
		send_word(CMD_WR_RIGHT, 4'hF, 32'h7FFF_FFFF);
		send_word(CMD_WR_LEFT, 4'h0, 32'h0000_0001);
		send_word(CMD_WR_RIGHT, 4'h0, 32'hFFFF_FFFF);
		send_word(CMD_WR_LEFT, 4'h5, 32'h0001_8000);
		send_word(CMD_WR_RIGHT, 4'h5, 32'hFFFE_4000);
		send_word(CMD_MULTIPLY, 4'h0, 32'h0);
		send_word(CMD_UNUSED, 4'h0, 32'h0);
		send_word(CMD_MULTIPLY, 4'h5, 32'h5555_AAAA);

		// Random words under the three idling patterns
		repeat (83) send_random_word();
		tx_idle_pct = 57;
		rx_idle_pct = 24;
		repeat (83) send_random_word();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (83) send_random_word();
		send_word(CMD_MULTIPLY, 4'h0, 32'h0);
		s_tvalid <= 1'b0;

		// Drain every outstanding product, then watch for stray words
		wait (pending_count == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d input words including %0d multiplies", words_sent,
			multiplies_sent);
		$display("compared %0d product words, %0d mismatches", checked_count, error_count);
		if (error_count == 0)
			$display("mat4_multiply_test: clean");
		else
			$display("mat4_multiply_test: errors");
		$finish;
	end

endmodule

/* mat4_multiply.f */
src/mat4_pkg.sv
src/mat4_mac_cell.sv
src/mat4_multiply.sv
tb/mat4_multiply_checker.sv
tb/mat4_multiply_test.sv
